[hw/rtl/mdhb_pkg.sv]
// shared types and constants of the decimated history buffer
package mdhb_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned TICK_W     = 15;
  localparam int unsigned INTV_W     = 16;
  localparam int unsigned MOTOR_W    = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned DIV_CNT_W  = 4;
  localparam int unsigned ZERO_CODE  = 775;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_RD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
  } rem_ctrl_t;

endpackage

[hw/rtl/mdhb_ram.sv]
// generic single write port ram with registered read
module mdhb_ram #(
  parameter int unsigned WIDTH  = 10,
  parameter int unsigned DEPTH  = 20,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mdhb_rem.sv]
// bit-serial remainder lane, one dividend bit per cycle while step is high, msb first
module mdhb_rem (
  input  logic                            clk_i,
  input  mdhb_pkg::rem_ctrl_t             ctrl_i,
  input  logic [mdhb_pkg::TICK_W-1:0]     dividend_i,
  input  logic [mdhb_pkg::INTV_W-1:0]     divisor_i,
  output logic                            hit_o
);

  logic [mdhb_pkg::TICK_W-1:0] shift_q, shift_d;
  logic [mdhb_pkg::INTV_W-1:0] rem_q, rem_d;
  logic [mdhb_pkg::INTV_W:0]   trial;
  logic [mdhb_pkg::INTV_W:0]   diff;

  always_comb begin
    trial   = {rem_q, shift_q[mdhb_pkg::TICK_W-1]};
    diff    = trial - {1'b0, divisor_i};
    shift_d = shift_q;
    rem_d   = rem_q;
    if (ctrl_i.start) begin
      shift_d = dividend_i;
      rem_d   = '0;
    end else if (ctrl_i.step) begin
      shift_d = {shift_q[mdhb_pkg::TICK_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[mdhb_pkg::INTV_W-1:0];
      end else begin
        rem_d = trial[mdhb_pkg::INTV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign hit_o = (divisor_i != '0) && (rem_q == '0);

endmodule

[hw/rtl/multichannel_decimated_history_buffer.sv]
// top level: per-motor decimated circular history with serial remainder lanes
// tick: accepted in ST_IDLE, bit-serial remainder in one lane per motor in ST_DIV,
//   then ST_WRITE stores each motor's sample if its interval divides the tick count
// dump: DEPTH samples of one motor, newest first, each through ST_RD (registered ram
//   read port) and ST_LOAD, which waits on a stalled output; tlast on the oldest
// clear: valid bits, pointers, fill code to 0; reset drops all valid bits so every slot
//   reads the zero-current code, pointers go to 0 and intervals to 1, no clearing pass
module multichannel_decimated_history_buffer #(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned DEPTH       = 5,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  // op, tick_count, sample_motor0.., dump_motor
  input  logic [((mdhb_pkg::OP_W + mdhb_pkg::TICK_W + CHANNELS * SAMPLE_BITS
                  + mdhb_pkg::MOTOR_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // history_sample, age_rank, source_motor
  output logic [((SAMPLE_BITS + ((DEPTH > 1) ? $clog2(DEPTH) : 1)
                  + mdhb_pkg::MOTOR_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [mdhb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mdhb_pkg::INTV_W-1:0]     cfg_data_i
);

  localparam int unsigned IN_W    = mdhb_pkg::OP_W + mdhb_pkg::TICK_W
                                    + CHANNELS * SAMPLE_BITS + mdhb_pkg::MOTOR_W;
  localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OUT_W   = SAMPLE_BITS + PTR_W + mdhb_pkg::MOTOR_W;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENTRIES = CHANNELS * DEPTH;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned TICK_LO = mdhb_pkg::OP_W;
  localparam int unsigned SAMP_LO = TICK_LO + mdhb_pkg::TICK_W;
  localparam int unsigned MOT_LO  = SAMP_LO + CHANNELS * SAMPLE_BITS;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(DEPTH);
  localparam logic [mdhb_pkg::DIV_CNT_W-1:0] DIV_LAST =
    mdhb_pkg::DIV_CNT_W'(mdhb_pkg::TICK_W - 1);

  mdhb_pkg::state_e state_q, state_d;

  logic [mdhb_pkg::INTV_W-1:0]    intv_q [CHANNELS];
  logic [PTR_W-1:0]               ptr_q  [CHANNELS];
  logic [SAMPLE_BITS-1:0]         samp_q [CHANNELS];
  logic [ENTRIES-1:0]             valid_q;
  logic [SAMPLE_BITS-1:0]         fill_q;
  logic [mdhb_pkg::TICK_W-1:0]    in_tick;
  logic [mdhb_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [CH_W-1:0]                ch_q;
  logic [CH_W-1:0]                motor_q;
  logic [PTR_W-1:0]               slot_q;
  logic [PTR_W-1:0]               rank_q;
  logic                           vld_rd_q;

  logic                           out_valid_q;
  logic [SAMPLE_BITS-1:0]         out_sample_q;
  logic [PTR_W-1:0]               out_rank_q;
  logic [mdhb_pkg::MOTOR_W-1:0]   out_motor_q;
  logic                           out_last_q;

  logic [CHANNELS-1:0]            hit;
  mdhb_pkg::rem_ctrl_t            rem_ctrl;
  logic                           in_acc;
  mdhb_pkg::op_e                  in_op;
  logic [mdhb_pkg::MOTOR_W-1:0]   in_motor;
  logic [4:0]                     motor_mod;
  logic                           ram_we;
  logic                           ram_re;
  logic [ADDR_W-1:0]              ram_waddr;
  logic [ADDR_W-1:0]              ram_raddr;
  logic [SAMPLE_BITS-1:0]         ram_rdata;
  logic                           out_load;
  logic                           store_hit;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op    = mdhb_pkg::op_e'(s_axis_tdata[mdhb_pkg::OP_W-1:0]);
  assign in_motor = s_axis_tdata[MOT_LO +: mdhb_pkg::MOTOR_W];
  assign in_tick  = s_axis_tdata[TICK_LO +: mdhb_pkg::TICK_W];

  // dump motor wrapped into the channel range
  always_comb begin
    motor_mod = {3'b000, in_motor};
    for (int i = 0; i < 3; i++) begin
      if (motor_mod >= 5'(CHANNELS)) begin
        motor_mod = motor_mod - 5'(CHANNELS);
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    mdhb_rem u_rem (
      .clk_i      (clk_i),
      .ctrl_i     (rem_ctrl),
      .dividend_i (in_tick),
      .divisor_i  (intv_q[c]),
      .hit_o      (hit[c])
    );
  end

  mdhb_ram #(
    .WIDTH  (SAMPLE_BITS),
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (samp_q[ch_q]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign store_hit = hit[ch_q];
  assign ram_waddr = ADDR_W'(ch_q) * DEPTH_A + ADDR_W'(ptr_q[ch_q]);
  assign ram_raddr = ADDR_W'(motor_q) * DEPTH_A + ADDR_W'(slot_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mdhb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            mdhb_pkg::OP_TICK: state_d = mdhb_pkg::ST_DIV;
            mdhb_pkg::OP_DUMP: state_d = mdhb_pkg::ST_RD;
            default:           state_d = mdhb_pkg::ST_IDLE;
          endcase
        end
      end
      mdhb_pkg::ST_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = mdhb_pkg::ST_WRITE;
        end
      end
      mdhb_pkg::ST_WRITE: begin
        if (ch_q == CH_LAST) begin
          state_d = mdhb_pkg::ST_IDLE;
        end
      end
      mdhb_pkg::ST_RD: state_d = mdhb_pkg::ST_LOAD;
      mdhb_pkg::ST_LOAD: begin
        if (out_load) begin
          state_d = (rank_q == PTR_LAST) ? mdhb_pkg::ST_IDLE : mdhb_pkg::ST_RD;
        end
      end
      default: state_d = mdhb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready  = 1'b0;
    rem_ctrl.start = 1'b0;
    rem_ctrl.step  = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      mdhb_pkg::ST_IDLE: begin
        s_axis_tready  = 1'b1;
        rem_ctrl.start = 1'b1;
      end
      mdhb_pkg::ST_DIV:   rem_ctrl.step = 1'b1;
      mdhb_pkg::ST_WRITE: ram_we = store_hit;
      mdhb_pkg::ST_RD:    ram_re = 1'b1;
      mdhb_pkg::ST_LOAD:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdhb_pkg::ST_IDLE;
      valid_q     <= '0;
      fill_q      <= SAMPLE_BITS'(mdhb_pkg::ZERO_CODE);
      div_cnt_q   <= '0;
      ch_q        <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        intv_q[c] <= mdhb_pkg::INTV_W'(1);
        ptr_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i && (cfg_addr_i < mdhb_pkg::CFG_ADDR_W'(CHANNELS))) begin
        intv_q[cfg_addr_i[CH_W-1:0]] <= cfg_data_i;
      end

      if (in_acc && (in_op == mdhb_pkg::OP_CLEAR)) begin
        valid_q <= '0;
        fill_q  <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          ptr_q[c] <= '0;
        end
      end

      if (state_q == mdhb_pkg::ST_IDLE) begin
        div_cnt_q <= '0;
        ch_q      <= '0;
        rank_q    <= '0;
      end
      if (state_q == mdhb_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (state_q == mdhb_pkg::ST_WRITE) begin
        ch_q <= ch_q + 1'b1;
        if (store_hit) begin
          valid_q[ram_waddr] <= 1'b1;
          ptr_q[ch_q]        <= (ptr_q[ch_q] == PTR_LAST) ? '0 : ptr_q[ch_q] + 1'b1;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        rank_q      <= rank_q + 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      motor_q <= CH_W'(motor_mod);
      for (int c = 0; c < CHANNELS; c++) begin
        samp_q[c] <= s_axis_tdata[SAMP_LO + c * SAMPLE_BITS +: SAMPLE_BITS];
      end
      slot_q <= (ptr_q[CH_W'(motor_mod)] == '0) ? PTR_LAST
                                                : ptr_q[CH_W'(motor_mod)] - 1'b1;
    end
    if (ram_re) begin
      vld_rd_q <= valid_q[ram_raddr];
    end
    if (out_load) begin
      out_sample_q <= vld_rd_q ? ram_rdata : fill_q;
      out_rank_q   <= rank_q;
      out_motor_q  <= mdhb_pkg::MOTOR_W'(motor_q);
      out_last_q   <= (rank_q == PTR_LAST);
      slot_q       <= (slot_q == '0) ? PTR_LAST : slot_q - 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_TW'({out_motor_q, out_rank_q, out_sample_q});

endmodule
